[sv/i2cms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    localparam int MAX_BYTES = 16;
    localparam int BUF_AW    = $clog2(MAX_BYTES);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    localparam int ADDR_W      = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [IN_TUSER_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [IN_TUSER_W-1:0] MODE_LOAD     = 3'd1;
    localparam logic [IN_TUSER_W-1:0] MODE_WRITE    = 3'd2;
    localparam logic [IN_TUSER_W-1:0] MODE_READ     = 3'd3;
    localparam logic [IN_TUSER_W-1:0] MODE_WRITE_RD = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR_0 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR_1 = 1'd1;

    typedef struct packed {
        logic [IN_TUSER_W-1:0] mode;
        logic                  port_select;
        logic [7:0]            tx_byte;
        logic [CNT_W-1:0]      write_len;
        logic [CNT_W-1:0]      read_len;
        logic                  sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       active_port;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       busy_res;
        logic       done_res;
        logic       error_status;
    } res_t;

endpackage

`default_nettype wire

[sv/i2cms_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cms_in_stage
    import i2cms_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic [IN_TUSER_W-1:0] s_tuser,
    input  wire logic                  fire,
    output logic                       item_valid,
    output item_t                      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign s_tready = !valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        item_next.mode        = s_tuser;
        item_next.port_select = s_tdata[0];
        item_next.tx_byte     = s_tdata[8:1];
        item_next.write_len   = s_tdata[13:9];
        item_next.read_len    = s_tdata[18:14];
        item_next.sda_in      = s_tdata[19];
        if (accept) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[sv/i2cms_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cms_seq
    import i2cms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    input  wire logic                 fire,
    input  wire item_t                item,
    output res_t                      res
);

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE     = 4'd0;
    localparam logic [PH_W-1:0] PH_START_W  = 4'd1;
    localparam logic [PH_W-1:0] PH_START_R  = 4'd2;
    localparam logic [PH_W-1:0] PH_TX_AW    = 4'd3;
    localparam logic [PH_W-1:0] PH_ACK_AW   = 4'd4;
    localparam logic [PH_W-1:0] PH_TX_AR    = 4'd5;
    localparam logic [PH_W-1:0] PH_ACK_AR   = 4'd6;
    localparam logic [PH_W-1:0] PH_TX_D     = 4'd7;
    localparam logic [PH_W-1:0] PH_ACK_D    = 4'd8;
    localparam logic [PH_W-1:0] PH_RX       = 4'd9;
    localparam logic [PH_W-1:0] PH_MACK     = 4'd10;
    localparam logic [PH_W-1:0] PH_STOP_OK  = 4'd11;
    localparam logic [PH_W-1:0] PH_STOP_ERR = 4'd12;

    localparam logic [1:0] KIND_WRITE    = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;
    localparam logic [1:0] KIND_WRITE_RD = 2'd3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

    logic [ADDR_W-1:0] addr0_reg, addr1_reg;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [2:0]        unit_reg, unit_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [CNT_W-1:0]  byte_reg, byte_next;
    logic [CNT_W-1:0]  load_reg, load_next;
    logic [CNT_W-1:0]  wlen_reg, wlen_next;
    logic [CNT_W-1:0]  rlen_reg, rlen_next;
    logic [1:0]        kind_reg, kind_next;
    logic              port_reg, port_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        wbuf_reg [MAX_BYTES];

    logic              is_begin;
    logic              buf_we;
    logic [BUF_AW-1:0] rd_idx;
    logic [7:0]        rd_byte;
    logic [CNT_W-1:0]  byte_inc;
    logic [3:0]        bit_inc;
    logic [7:0]        rx_shift;
    logic [CNT_W-1:0]  wl_sat, rl_sat;
    logic [ADDR_W-1:0] cur_addr;
    logic [PH_W-1:0]   ph;
    logic [2:0]        u;
    logic              scl, sda, drv, rxv, busy, done;
    logic [7:0]        rxb;

    assign byte_inc = byte_reg + CNT_W'(1);
    assign bit_inc  = bit_reg + 4'd1;
    assign rx_shift = {shift_reg[6:0], item.sda_in};
    assign rd_idx   = (phase_reg == PH_ACK_D) ? byte_inc[BUF_AW-1:0] : '0;
    assign rd_byte  = wbuf_reg[rd_idx];
    assign wl_sat   = (item.write_len > MAX_CNT) ? MAX_CNT : item.write_len;
    assign rl_sat   = (item.read_len > MAX_CNT) ? MAX_CNT : item.read_len;
    assign is_begin = (phase_reg == PH_IDLE) && (item.mode == MODE_WRITE
                      || item.mode == MODE_READ || item.mode == MODE_WRITE_RD);
    assign buf_we   = (phase_reg == PH_IDLE) && (item.mode == MODE_LOAD)
                      && (load_reg < MAX_CNT);

    always_comb begin
        phase_next  = phase_reg;
        unit_next   = unit_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        byte_next   = byte_reg;
        load_next   = load_reg;
        wlen_next   = wlen_reg;
        rlen_next   = rlen_reg;
        kind_next   = kind_reg;
        port_next   = port_reg;
        status_next = status_reg;
        scl  = 1'b1;
        sda  = 1'b1;
        drv  = 1'b1;
        rxv  = 1'b0;
        rxb  = 8'h00;
        busy = 1'b1;
        done = 1'b0;
        ph   = phase_reg;
        u    = unit_reg;

        if (buf_we) begin
            load_next = load_reg + CNT_W'(1);
        end
        if (is_begin) begin
            port_next = item.port_select;
            kind_next = 2'(item.mode - MODE_LOAD);
            wlen_next = (item.mode != MODE_READ) ? wl_sat : '0;
            rlen_next = (item.mode != MODE_WRITE) ? rl_sat : '0;
            byte_next = '0;
            load_next = '0;
            ph        = (item.mode == MODE_READ) ? PH_START_R : PH_START_W;
            u         = 3'd1;
        end else if (phase_reg == PH_IDLE) begin
            busy = 1'b0;
        end
        phase_next = ph;
        unit_next  = u;
        cur_addr   = port_next ? addr1_reg : addr0_reg;

        case (ph)
            PH_START_W, PH_START_R: begin
                scl = (u != 3'd0);
                sda = (u != 3'd2);
                if (u >= 3'd2) begin
                    shift_next = {cur_addr, (ph == PH_START_R)};
                    bit_next   = 4'd0;
                    phase_next = (ph == PH_START_R) ? PH_TX_AR : PH_TX_AW;
                    unit_next  = 3'd0;
                end else begin
                    unit_next = u + 3'd1;
                end
            end
            PH_TX_AW, PH_TX_AR, PH_TX_D: begin
                scl = (u == 3'd2);
                sda = shift_reg[7];
                if (u >= 3'd2) begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    unit_next  = 3'd0;
                    if (bit_inc >= 4'd8) begin
                        phase_next = ph + PH_W'(1);
                    end
                end else begin
                    unit_next = u + 3'd1;
                end
            end
            PH_ACK_AW, PH_ACK_AR, PH_ACK_D: begin
                scl = (u == 3'd2);
                drv = 1'b0;
                if (u < 3'd2) begin
                    unit_next = u + 3'd1;
                end else begin
                    unit_next = 3'd0;
                    if (item.sda_in) begin
                        status_next[port_reg] = 1'b0;
                        phase_next = PH_STOP_ERR;
                    end else if (ph == PH_ACK_AR) begin
                        byte_next = '0;
                        if (rlen_reg != '0) begin
                            shift_next = 8'h00;
                            bit_next   = 4'd0;
                            phase_next = PH_RX;
                        end else begin
                            phase_next = PH_STOP_OK;
                        end
                    end else begin
                        byte_next = (ph == PH_ACK_D) ? byte_inc : '0;
                        if (((ph == PH_ACK_D) ? byte_inc : '0) < wlen_reg) begin
                            shift_next = rd_byte;
                            bit_next   = 4'd0;
                            phase_next = PH_TX_D;
                        end else if (kind_reg == KIND_WRITE_RD) begin
                            phase_next = PH_START_R;
                        end else begin
                            phase_next = PH_STOP_OK;
                        end
                    end
                end
            end
            PH_RX: begin
                scl = (u != 3'd0);
                drv = 1'b0;
                if (u == 3'd0) begin
                    unit_next = 3'd1;
                end else begin
                    shift_next = rx_shift;
                    bit_next   = bit_inc;
                    unit_next  = 3'd0;
                    if (bit_inc >= 4'd8) begin
                        rxv        = 1'b1;
                        rxb        = rx_shift;
                        phase_next = PH_MACK;
                    end
                end
            end
            PH_MACK: begin
                scl = (u >= 3'd2);
                sda = (byte_inc >= rlen_reg);
                if (u >= 3'd3) begin
                    byte_next = byte_inc;
                    unit_next = 3'd0;
                    if (byte_inc < rlen_reg) begin
                        shift_next = 8'h00;
                        bit_next   = 4'd0;
                        phase_next = PH_RX;
                    end else begin
                        phase_next = PH_STOP_OK;
                    end
                end else begin
                    unit_next = u + 3'd1;
                end
            end
            PH_STOP_OK, PH_STOP_ERR: begin
                scl = (u >= 3'd2);
                sda = (u >= 3'd3);
                if (u >= 3'd3) begin
                    done = 1'b1;
                    if (ph == PH_STOP_OK) begin
                        status_next[port_reg] = 1'b1;
                    end
                    phase_next = PH_IDLE;
                    unit_next  = 3'd0;
                end else begin
                    unit_next = u + 3'd1;
                end
            end
            PH_IDLE: begin
            end
            default: begin
                phase_next = PH_IDLE;
                unit_next  = 3'd0;
            end
        endcase

        res.scl_out      = scl;
        res.sda_out      = drv ? sda : 1'b1;
        res.sda_drive    = drv;
        res.active_port  = port_next;
        res.rx_byte      = rxb;
        res.rx_valid     = rxv;
        res.busy_res     = busy;
        res.done_res     = done;
        res.error_status = !status_next[port_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr0_reg  <= '0;
            addr1_reg  <= '0;
            phase_reg  <= PH_IDLE;
            unit_reg   <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            byte_reg   <= '0;
            load_reg   <= '0;
            wlen_reg   <= '0;
            rlen_reg   <= '0;
            kind_reg   <= '0;
            port_reg   <= 1'b0;
            status_reg <= '0;
        end else begin
            if (cfg_valid && cfg_index == REG_SLAVE_ADDR_0) begin
                addr0_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_SLAVE_ADDR_1) begin
                addr1_reg <= cfg_data;
            end
            if (fire) begin
                phase_reg  <= phase_next;
                unit_reg   <= unit_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                byte_reg   <= byte_next;
                load_reg   <= load_next;
                wlen_reg   <= wlen_next;
                rlen_reg   <= rlen_next;
                kind_reg   <= kind_next;
                port_reg   <= port_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && buf_we) begin
            wbuf_reg[load_reg[BUF_AW-1:0]] <= item.tx_byte;
        end
    end

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.done_res |=> phase_reg == PH_IDLE)
        else $error("stop finished but sequencer not idle");

    a_rx_to_mack: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.rx_valid |=> phase_reg == PH_MACK)
        else $error("received byte not followed by master ack");

    a_busy_when_active: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && phase_reg != PH_IDLE |-> res.busy_res)
        else $error("transfer unit reported not busy");

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        load_reg <= MAX_CNT && byte_reg <= MAX_CNT && bit_reg <= 4'd8)
        else $error("counter out of range");

    a_kind_wr_rd_len: assert property (@(posedge aclk) disable iff (!aresetn)
        kind_reg == KIND_READ && phase_reg != PH_IDLE |-> wlen_reg == '0)
        else $error("read transfer holds a write length");
`endif

endmodule

`default_nettype wire

[sv/i2cms_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cms_out_stage
    import i2cms_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   item_valid,
    input  wire res_t                   res,
    output logic                        fire,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic [OUT_TDATA_W-1:0] data_next;

    assign fire = item_valid && (!valid_reg || m_tready);

    always_comb begin
        data_next = {res.error_status, res.done_res, res.busy_res, res.rx_valid,
                     res.rx_byte, res.active_port, res.sda_drive, res.sda_out,
                     res.scl_out};
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (fire) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

[sv/i2c_master_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           content
// s_        in   s_tvalid/s_tready   s_tuser mode, s_tdata fields of one time unit
// m_        out  m_tvalid/m_tready   m_tdata pin levels and status of that unit
// cfg_      in   cfg_valid/cfg_ready cfg_index register, cfg_data 7-bit address
//
// one word in, one word out; a word is held in the input register,
// the step logic runs between it and the output register, and a new word is taken
// every cycle while m_tready stays high
// aresetn (synchronous) returns the sequencer to idle, both ports flagged in error
// a stalled output holds its word and the input register, then s_tready drops
// cfg_ready is always high

module i2c_master_sequencer
    import i2cms_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // [0] port_select, [8:1] tx_byte, [13:9] write_len, [18:14] read_len,
    // [19] sda_in, [23:20] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive, [3] active_port, [11:4] rx_byte,
    // [12] rx_valid, [13] busy_res, [14] done_res, [15] error_status
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ADDR_W-1:0]      cfg_data
);

    logic  fire;
    logic  item_valid;
    item_t item;
    res_t  res;

    assign cfg_ready = 1'b1;

    i2cms_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cms_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .res       (res)
    );

    i2cms_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .res        (res),
        .fire       (fire),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import i2cms_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START_WR, ST_START_RD, ST_ADDR_WR, ST_ACK_ADDR_WR, ST_ADDR_RD,
        ST_ACK_ADDR_RD, ST_DATA, ST_ACK_DATA, ST_RECV, ST_MASTER_ACK, ST_STOP,
        ST_STOP_ABORT
    } bus_state_t;

    typedef enum logic [1:0] {XFER_NONE, XFER_WR, XFER_RD, XFER_WR_RD} xfer_kind_t;

    localparam logic [IN_TUSER_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [IN_TUSER_W-1:0] MODE_UNUSED_HI = 3'd7;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int GAP_MAX        = 11;
    localparam int RANDOM_UNITS   = 1000;
    localparam int REPORT_LIMIT   = 100;
    localparam int NACK_NONE      = -1;
    localparam int NACK_RANDOM    = -2;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = MODE_TICK;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_SLAVE_ADDR_0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    // sequencer state as predicted
    bus_state_t       st_phase = ST_IDLE;
    logic [2:0]       st_unit = '0;
    logic [3:0]       st_bits = '0;
    logic [7:0]       st_shift = '0;
    logic [CNT_W-1:0] st_nbytes = '0;
    logic [CNT_W-1:0] st_load = '0;
    logic [CNT_W-1:0] st_wlen = '0;
    logic [CNT_W-1:0] st_rlen = '0;
    logic [7:0]       st_buf [MAX_BYTES];
    xfer_kind_t       st_kind = XFER_NONE;
    logic             st_port = 1'b0;
    logic [1:0]       st_ok = 2'b00;
    logic [ADDR_W-1:0] addr0 = '0;
    logic [ADDR_W-1:0] addr1 = '0;
    int               buf_hi = 0;

    res_t expected_units[$];
    int   errors = 0;
    int   units_sent = 0;
    int   gap_max = 0;
    int   stall_max = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    i2c_master_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic void enter(input bus_state_t p);
        st_phase = p;
        st_unit = 3'd0;
    endfunction

    function automatic void load_shifter(input logic [7:0] v, input bus_state_t p);
        st_shift = v;
        st_bits = 4'd0;
        enter(p);
    endfunction

    function automatic void after_writes();
        if (st_kind == XFER_WR_RD) enter(ST_START_RD);
        else enter(ST_STOP);
    endfunction

    function automatic logic [CNT_W-1:0] clip_len(input logic [CNT_W-1:0] n);
        return (n > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : n;
    endfunction

    // one time unit of the bus sequencer
    function automatic res_t seq_unit(input logic [2:0] mode, input logic port,
                                      input logic [7:0] txb, input logic [CNT_W-1:0] wl,
                                      input logic [CNT_W-1:0] rl, input logic sda_in);
        res_t r;
        logic scl, sda, drv, busy, done, rxv;
        logic [7:0] rxb;
        logic [2:0] u;
        logic [ADDR_W-1:0] target;
        scl = 1'b1; sda = 1'b1; drv = 1'b1; busy = 1'b1; done = 1'b0; rxv = 1'b0;
        rxb = 8'h00;
        if (st_phase == ST_IDLE) begin
            if (mode == MODE_LOAD && st_load < CNT_W'(MAX_BYTES)) begin
                st_buf[st_load[BUF_AW-1:0]] = txb;
                st_load = st_load + 1'b1;
                if (int'(st_load) > buf_hi) buf_hi = int'(st_load);
            end
            if (mode >= MODE_WRITE && mode <= MODE_WRITE_RD) begin
                st_port = port;
                if (mode == MODE_WRITE) st_kind = XFER_WR;
                else if (mode == MODE_READ) st_kind = XFER_RD;
                else st_kind = XFER_WR_RD;
                st_wlen = (st_kind != XFER_RD) ? clip_len(wl) : '0;
                st_rlen = (st_kind != XFER_WR) ? clip_len(rl) : '0;
                st_nbytes = '0;
                st_load = '0;
                st_phase = (mode == MODE_READ) ? ST_START_RD : ST_START_WR;
                st_unit = 3'd1;
            end else begin
                busy = 1'b0;
            end
        end
        u = st_unit;
        target = st_port ? addr1 : addr0;
        case (st_phase)
            ST_START_WR, ST_START_RD: begin
                scl = (u != 3'd0);
                sda = (u != 3'd2);
                if (u >= 3'd2) begin
                    if (st_phase == ST_START_WR) load_shifter({target, 1'b0}, ST_ADDR_WR);
                    else load_shifter({target, 1'b1}, ST_ADDR_RD);
                end else begin
                    st_unit = u + 3'd1;
                end
            end
            ST_ADDR_WR, ST_ADDR_RD, ST_DATA: begin
                scl = (u == 3'd2);
                sda = st_shift[7];
                if (u >= 3'd2) begin
                    st_shift = {st_shift[6:0], 1'b0};
                    st_bits = st_bits + 4'd1;
                    st_unit = 3'd0;
                    if (st_bits >= 4'd8) begin
                        if (st_phase == ST_ADDR_WR) enter(ST_ACK_ADDR_WR);
                        else if (st_phase == ST_ADDR_RD) enter(ST_ACK_ADDR_RD);
                        else enter(ST_ACK_DATA);
                    end
                end else begin
                    st_unit = u + 3'd1;
                end
            end
            ST_ACK_ADDR_WR, ST_ACK_ADDR_RD, ST_ACK_DATA: begin
                scl = (u == 3'd2);
                drv = 1'b0;
                if (u < 3'd2) begin
                    st_unit = u + 3'd1;
                end else if (sda_in) begin
                    st_ok[st_port] = 1'b0;
                    enter(ST_STOP_ABORT);
                end else if (st_phase == ST_ACK_ADDR_WR) begin
                    st_nbytes = '0;
                    if (st_wlen != '0) load_shifter(st_buf[0], ST_DATA);
                    else after_writes();
                end else if (st_phase == ST_ACK_DATA) begin
                    st_nbytes = st_nbytes + 1'b1;
                    if (st_nbytes < st_wlen) load_shifter(st_buf[st_nbytes[BUF_AW-1:0]], ST_DATA);
                    else after_writes();
                end else begin
                    st_nbytes = '0;
                    if (st_rlen != '0) load_shifter(8'h00, ST_RECV);
                    else enter(ST_STOP);
                end
            end
            ST_RECV: begin
                scl = (u != 3'd0);
                drv = 1'b0;
                if (u == 3'd0) begin
                    st_unit = 3'd1;
                end else begin
                    st_shift = {st_shift[6:0], sda_in};
                    st_bits = st_bits + 4'd1;
                    st_unit = 3'd0;
                    if (st_bits >= 4'd8) begin
                        rxv = 1'b1;
                        rxb = st_shift;
                        enter(ST_MASTER_ACK);
                    end
                end
            end
            ST_MASTER_ACK: begin
                scl = (u >= 3'd2);
                sda = (int'(st_nbytes) + 1 >= int'(st_rlen));
                if (u >= 3'd3) begin
                    st_nbytes = st_nbytes + 1'b1;
                    if (st_nbytes < st_rlen) load_shifter(8'h00, ST_RECV);
                    else enter(ST_STOP);
                end else begin
                    st_unit = u + 3'd1;
                end
            end
            ST_STOP, ST_STOP_ABORT: begin
                scl = (u >= 3'd2);
                sda = (u >= 3'd3);
                if (u >= 3'd3) begin
                    done = 1'b1;
                    if (st_phase == ST_STOP) st_ok[st_port] = 1'b1;
                    enter(ST_IDLE);
                end else begin
                    st_unit = u + 3'd1;
                end
            end
            default: ;
        endcase
        r = '0;
        r.scl_out = scl;
        r.sda_drive = drv;
        r.sda_out = drv ? sda : 1'b1;
        r.active_port = st_port;
        r.rx_byte = rxv ? rxb : 8'h00;
        r.rx_valid = rxv;
        r.busy_res = busy;
        r.done_res = done;
        r.error_status = !st_ok[st_port];
        return r;
    endfunction

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT) $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_unit(input logic [OUT_TDATA_W-1:0] d);
        res_t e;
        if (expected_units.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) $error("word %h arrived with nothing expected", d);
        end else begin
            e = expected_units.pop_front();
            cmp_field("scl_out", e.scl_out, d[0]);
            cmp_field("sda_out", e.sda_out, d[1]);
            cmp_field("sda_drive", e.sda_drive, d[2]);
            cmp_field("active_port", e.active_port, d[3]);
            cmp_field("rx_byte", e.rx_byte, d[11:4]);
            cmp_field("rx_valid", e.rx_valid, d[12]);
            cmp_field("busy_res", e.busy_res, d[13]);
            cmp_field("done_res", e.done_res, d[14]);
            cmp_field("error_status", e.error_status, d[15]);
        end
    endtask

    // result side with random stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_unit(m_tdata);
                stall_left = $urandom_range(stall_max, 0);
                if (stall_left > 0) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (stall_left == 0) m_tready <= 1'b1;
                else stall_left--;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_unit(input logic [2:0] mode, input logic port, input logic [7:0] txb,
                             input logic [CNT_W-1:0] wl, input logic [CNT_W-1:0] rl,
                             input logic sda_in);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser <= mode;
        s_tdata <= {4'b0000, sda_in, rl, wl, txb, port};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        units_sent++;
        expected_units.push_back(seq_unit(mode, port, txb, wl, rl, sda_in));
    endtask

    task automatic idle_unit(input logic [2:0] mode);
        send_unit(mode, 1'($urandom), 8'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                  1'($urandom));
    endtask

    task automatic load_bytes(input int n);
        repeat (n) idle_unit(MODE_LOAD);
    endtask

    // ticks until the stop completes; nack_at picks which ack check fails
    task automatic run_to_idle(input int nack_at, input bit strays);
        int acks;
        logic sda;
        logic [2:0] mode;
        acks = 0;
        while (st_phase != ST_IDLE) begin
            sda = 1'($urandom);
            if ((st_phase == ST_ACK_ADDR_WR || st_phase == ST_ACK_ADDR_RD ||
                 st_phase == ST_ACK_DATA) && st_unit == 3'd2) begin
                sda = (acks == nack_at) ||
                      (nack_at == NACK_RANDOM && $urandom_range(15, 0) == 0);
                acks++;
            end
            mode = MODE_TICK;
            if (strays && $urandom_range(3, 0) == 0) mode = 3'($urandom_range(7, 1));
            send_unit(mode, 1'($urandom), 8'($urandom), CNT_W'($urandom), CNT_W'($urandom), sda);
        end
    endtask

    task automatic xfer(input logic [2:0] mode, input logic port, input logic [CNT_W-1:0] wl,
                        input logic [CNT_W-1:0] rl, input int nack_at, input bit strays);
        send_unit(mode, port, 8'($urandom), wl, rl, 1'($urandom));
        run_to_idle(nack_at, strays);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_addrs(input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] a1);
        settle();
        cfg_index <= REG_SLAVE_ADDR_0;
        cfg_data <= a0;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        addr0 = a0;
        cfg_index <= REG_SLAVE_ADDR_1;
        cfg_data <= a1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        addr1 = a1;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_idle_units();
        gap_max = 0;
        stall_max = 0;
        repeat (3) idle_unit(MODE_TICK);
        for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) idle_unit(3'(m));
    endtask

    task automatic test_addr_extremes();
        set_addrs('0, '1);
    endtask

    task automatic test_buffer_full();
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
        send_unit(MODE_LOAD, 1'b0, 8'h00, '0, '0, 1'b0);
        send_unit(MODE_LOAD, 1'b1, 8'hff, '1, '1, 1'b1);
        // one more load than fits
        load_bytes(MAX_BYTES - 1);
        xfer(MODE_WRITE, 1'b0, CNT_W'(MAX_BYTES), '0, NACK_NONE, 1'b0);
    endtask

    task automatic test_zero_lengths();
        xfer(MODE_WRITE, 1'b1, '0, CNT_W'($urandom), NACK_NONE, 1'b0);
        xfer(MODE_READ, 1'b0, CNT_W'($urandom), '0, NACK_NONE, 1'b0);
        xfer(MODE_WRITE_RD, 1'b1, '0, '0, NACK_NONE, 1'b0);
    endtask

    task automatic test_write_then_read();
        gap_max = 0;
        stall_max = 0;
        load_bytes(3);
        xfer(MODE_WRITE_RD, 1'b1, 5'd3, 5'd4, NACK_NONE, 1'b0);
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
        xfer(MODE_READ, 1'b0, 5'd31, 5'd2, NACK_NONE, 1'b0);
    endtask

    task automatic test_long_lengths();
        gap_max = 2;
        stall_max = 2;
        xfer(MODE_WRITE, 1'b0, 5'd31, 5'd31, NACK_NONE, 1'b0);
        xfer(MODE_READ, 1'b1, 5'd0, 5'd16, NACK_NONE, 1'b0);
        xfer(MODE_WRITE_RD, 1'b0, 5'd17, 5'd20, NACK_NONE, 1'b0);
    endtask

    task automatic test_nack_abort();
        gap_max = GAP_MAX;
        stall_max = GAP_MAX;
        // address, second data byte, read address, then a clean one, a last-byte nack and a read address nack
        xfer(MODE_WRITE, 1'b0, 5'd2, 5'd0, 0, 1'b0);
        xfer(MODE_WRITE, 1'b0, 5'd3, 5'd0, 2, 1'b0);
        xfer(MODE_WRITE_RD, 1'b1, 5'd2, 5'd2, 3, 1'b0);
        xfer(MODE_READ, 1'b1, 5'd0, 5'd1, NACK_NONE, 1'b0);
        xfer(MODE_WRITE, 1'b1, 5'd1, 5'd0, 1, 1'b0);
        xfer(MODE_READ, 1'b0, 5'd0, 5'd1, 0, 1'b0);
    endtask

    task automatic test_busy_commands();
        xfer(MODE_WRITE_RD, 1'b0, 5'd2, 5'd2, NACK_NONE, 1'b1);
        xfer(MODE_WRITE, 1'b1, 5'd1, 5'd1, NACK_NONE, 1'b1);
    endtask

    task automatic test_addr_swap();
        set_addrs('1, '0);
        xfer(MODE_WRITE_RD, 1'b0, 5'd1, 5'd1, NACK_NONE, 1'b0);
        xfer(MODE_WRITE_RD, 1'b1, 5'd1, 5'd1, NACK_NONE, 1'b0);
    endtask

    task automatic test_random_traffic();
        int start;
        logic [2:0] mode;
        logic [CNT_W-1:0] wl, rl;
        start = units_sent;
        while (units_sent - start < RANDOM_UNITS) begin
            if ($urandom_range(5, 0) == 0) begin
                gap_max = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
                stall_max = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            end
            if ($urandom_range(11, 0) == 0) set_addrs(ADDR_W'($urandom), ADDR_W'($urandom));
            repeat ($urandom_range(2, 0)) idle_unit(3'($urandom_range(7, 0)));
            load_bytes($urandom_range(3, 0));
            mode = MODE_WRITE + 3'($urandom_range(2, 0));
            wl = ($urandom_range(9, 0) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(3, 0));
            rl = ($urandom_range(9, 0) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(3, 0));
            // never send a buffer entry that was not loaded
            if (mode != MODE_READ && int'(clip_len(wl)) > buf_hi) wl = CNT_W'(buf_hi);
            xfer(mode, 1'($urandom), wl, rl, NACK_RANDOM, $urandom_range(3, 0) == 0);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_units();
        test_addr_extremes();
        test_buffer_full();
        test_zero_lengths();
        test_write_then_read();
        test_long_lengths();
        test_nack_abort();
        test_busy_commands();
        test_addr_swap();
        test_random_traffic();
        settle();
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
